### rtl/core/usb_transfer_ring_producer_defines.svh
// Assertion macros used by the transfer ring producer checker.
`ifndef USB_TRANSFER_RING_PRODUCER_DEFINES_SVH
`define USB_TRANSFER_RING_PRODUCER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define UTRP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("transfer ring producer check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define UTRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("transfer ring producer check failed");

`endif

### rtl/core/utrp_pkg.sv
// Types and constants of the transfer ring producer.
package utrp_pkg;

  typedef enum logic [1:0] {
    OP_OPEN = 2'd0,
    OP_INTR = 2'd1,
    OP_BULK = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    RES_OK     = 2'd0,
    RES_RANGE  = 2'd1,
    RES_CLOSED = 2'd2
  } res_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_WRAP
  } state_e;

  // TRB control word pieces
  localparam logic [31:0] LINK_CTRL   = (32'd6 << 10) | (32'd1 << 1);
  localparam logic [31:0] NORMAL_CTRL = (32'd1 << 10) | (32'd1 << 5);
  localparam logic [31:0] ISP_BIT     = 32'd1 << 2;

  // Request range limits and endpoint address decoding
  localparam logic [7:0] SLOT_REJECT  = 8'd255;
  localparam logic [7:0] DCI_LIMIT    = 8'd32;
  localparam logic [7:0] EPA_NUM_MASK = 8'h0F;
  localparam int         EPA_DIR_BIT  = 7;

  typedef struct packed {
    logic [7:0]  slot;
    logic [4:0]  dci;
    logic [7:0]  entry;
    logic [63:0] param;
    logic [31:0] status;
    logic [31:0] ctrl;
    logic        full;
    logic        bell;
    res_e        code;
    logic        last;
  } result_t;

endpackage

### rtl/core/utrp_ep_table.sv
// Endpoint state memory with a clearing sweep after reset.
module utrp_ep_table #(
  parameter int DEPTH  = 8192,
  parameter int DATA_W = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]        rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]        wr_data_i,
  output logic                     busy_o
);

  localparam int ADDR_W = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic              clr_busy_q, clr_busy_d;

  // Advance the clearing sweep one entry a cycle
  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + ADDR_W'(1);
      if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // Write the sweep or the update; read with registered data
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_busy_q;

endmodule

### rtl/core/usb_transfer_ring_producer.sv
// Top level of the transfer ring producer: request decode, endpoint update, TRB output.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------------
//   in      | input     | in_valid_i/in_ready_o | operation, slot, dci, endpoint address,
//           |           |                      | address, length
//   out     | output    | out_valid_o/out_ready_i | ring, entry, TRB words, flags, code
//
// A request is taken in idle; the endpoint entry is read from the state memory into a
// register and written back as the first result loads. A ring wrap through its link
// TRB adds the ST_WRAP state, and no new request is taken until the sequencer is idle.
// After reset a sweep clears SLOT_COUNT * ENDPOINTS_PER_SLOT entries (8192 by default)
// with in_ready_o low. A stalled output holds the sequencer in place.
module usb_transfer_ring_producer #(
  parameter int RING_ENTRIES       = 256,
  parameter int SLOT_COUNT         = 256,
  parameter int ENDPOINTS_PER_SLOT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  slot_i,
  input  logic [7:0]  dci_i,
  input  logic [7:0]  endpoint_address_i,
  input  logic [63:0] address_i,
  input  logic [31:0] length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_slot_o,
  output logic [4:0]  out_dci_o,
  output logic [7:0]  entry_index_o,
  output logic [63:0] parameter_word_o,
  output logic [31:0] status_word_o,
  output logic [31:0] control_word_o,
  output logic        write_full_o,
  output logic        ring_doorbell_o,
  output logic [1:0]  result_code_o,
  output logic        last_o
);

  localparam int IDX_W  = $clog2(RING_ENTRIES);
  localparam int DEPTH  = SLOT_COUNT * ENDPOINTS_PER_SLOT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ENT_W  = IDX_W + 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_ENTRIES - 1);

  // Low eight bits of a ring index, zero extended for small rings
  function automatic logic [7:0] entry_of(input logic [IDX_W-1:0] idx);
    logic [IDX_W+7:0] ext;
    ext = {8'b0, idx};
    return ext[7:0];
  endfunction

  // Normal TRB control word for a queue operation
  function automatic logic [31:0] normal_ctrl(input utrp_pkg::op_e op, input logic cyc);
    logic [31:0] w;
    w = utrp_pkg::NORMAL_CTRL | {31'b0, cyc};
    if (op == utrp_pkg::OP_INTR) begin
      w = w | utrp_pkg::ISP_BIT;
    end
    return w;
  endfunction

  utrp_pkg::state_e  state_q, state_d;
  utrp_pkg::op_e     op_in, op_q;
  utrp_pkg::result_t res, out_q;
  logic              out_valid_q, out_valid_d;
  logic              out_free, load;
  logic              accept, op_known_in, op_known_q;
  logic [7:0]        num_bits;
  logic [4:0]        ep_open, ep_idx;
  logic              range_err, range_err_q;
  logic [7:0]        slot_q;
  logic [4:0]        dci_q;
  logic [63:0]       buf_addr_q;
  logic [31:0]       len_q;
  logic [ADDR_W-1:0] rd_addr, tbl_addr_q;
  logic              rd_en, tbl_busy;
  logic [ENT_W-1:0]  rd_data, wr_data;
  logic              wr_en;
  logic              cur_open, cur_cycle;
  logic [IDX_W-1:0]  cur_idx;
  logic              need_wrap;
  logic              wrap_cycle_q, wrap_cycle_d;

  // Decode the incoming request
  assign op_in       = utrp_pkg::op_e'(operation_i);
  assign op_known_in = (op_in == utrp_pkg::OP_OPEN) || (op_in == utrp_pkg::OP_INTR) ||
                       (op_in == utrp_pkg::OP_BULK);
  assign num_bits    = endpoint_address_i & utrp_pkg::EPA_NUM_MASK;
  assign ep_open     = {num_bits[3:0], endpoint_address_i[utrp_pkg::EPA_DIR_BIT]};
  assign ep_idx      = (op_in == utrp_pkg::OP_OPEN) ? ep_open : dci_i[4:0];

  always_comb begin
    if (op_in == utrp_pkg::OP_OPEN) begin
      range_err = (int'(slot_i) >= SLOT_COUNT) || (int'(ep_open) >= ENDPOINTS_PER_SLOT);
    end else begin
      range_err = (slot_i >= utrp_pkg::SLOT_REJECT) || (int'(slot_i) >= SLOT_COUNT) ||
                  (dci_i >= utrp_pkg::DCI_LIMIT) || (int'(dci_i) >= ENDPOINTS_PER_SLOT);
    end
  end

  assign in_ready_o = (state_q == utrp_pkg::ST_IDLE) && !tbl_busy;
  assign accept     = in_valid_i && in_ready_o;
  assign rd_en      = accept && op_known_in && !range_err;
  assign rd_addr    = ADDR_W'(32'(slot_i) * 32'(ENDPOINTS_PER_SLOT) + 32'(ep_idx));

  // Endpoint entry as read back
  assign cur_open  = rd_data[ENT_W-1];
  assign cur_cycle = rd_data[ENT_W-2];
  assign cur_idx   = rd_data[IDX_W-1:0];
  assign need_wrap = ((op_q == utrp_pkg::OP_INTR) || (op_q == utrp_pkg::OP_BULK)) &&
                     !range_err_q && cur_open && (cur_idx == LAST_IDX);
  assign out_free  = !out_valid_q || out_ready_i;

  utrp_ep_table #(
    .DEPTH  (DEPTH),
    .DATA_W (ENT_W)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (tbl_addr_q),
    .wr_data_i (wr_data),
    .busy_o    (tbl_busy)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      utrp_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = utrp_pkg::ST_LOOKUP;
        end
      end
      utrp_pkg::ST_LOOKUP: begin
        if (!op_known_q) begin
          state_d = utrp_pkg::ST_IDLE;
        end else if (out_free) begin
          state_d = need_wrap ? utrp_pkg::ST_WRAP : utrp_pkg::ST_IDLE;
        end
      end
      utrp_pkg::ST_WRAP: begin
        if (out_free) begin
          state_d = utrp_pkg::ST_IDLE;
        end
      end
      default: state_d = utrp_pkg::ST_IDLE;
    endcase
  end

  // Build results and the endpoint update
  always_comb begin
    res          = '0;
    res.code     = utrp_pkg::RES_OK;
    load         = 1'b0;
    wr_en        = 1'b0;
    wr_data      = '0;
    wrap_cycle_d = wrap_cycle_q;
    unique case (state_q)
      utrp_pkg::ST_LOOKUP: begin
        if (out_free && op_known_q) begin
          load     = 1'b1;
          res.last = 1'b1;
          if (range_err_q) begin
            res.code = utrp_pkg::RES_RANGE;
          end else if (op_q == utrp_pkg::OP_OPEN) begin
            // Restart the ring and emit its link TRB
            wr_en      = 1'b1;
            wr_data    = {1'b1, 1'b1, {IDX_W{1'b0}}};
            res.slot   = slot_q;
            res.dci    = dci_q;
            res.entry  = entry_of(LAST_IDX);
            res.param  = buf_addr_q;
            res.ctrl   = utrp_pkg::LINK_CTRL | 32'd1;
            res.full   = 1'b1;
          end else if (!cur_open) begin
            res.code = utrp_pkg::RES_CLOSED;
          end else if (need_wrap) begin
            // Rewrite the link control word, then toggle the cycle bit
            wr_en        = 1'b1;
            wr_data      = {1'b1, !cur_cycle, IDX_W'(1)};
            wrap_cycle_d = !cur_cycle;
            res.slot     = slot_q;
            res.dci      = dci_q;
            res.entry    = entry_of(cur_idx);
            res.ctrl     = utrp_pkg::LINK_CTRL | {31'b0, cur_cycle};
            res.last     = 1'b0;
          end else begin
            wr_en      = 1'b1;
            wr_data    = {1'b1, cur_cycle, cur_idx + IDX_W'(1)};
            res.slot   = slot_q;
            res.dci    = dci_q;
            res.entry  = entry_of(cur_idx);
            res.param  = buf_addr_q;
            res.status = len_q;
            res.ctrl   = normal_ctrl(op_q, cur_cycle);
            res.full   = 1'b1;
            res.bell   = 1'b1;
          end
        end
      end
      utrp_pkg::ST_WRAP: begin
        // Emit the normal TRB at the ring start
        if (out_free) begin
          load       = 1'b1;
          res.slot   = slot_q;
          res.dci    = dci_q;
          res.entry  = entry_of('0);
          res.param  = buf_addr_q;
          res.status = len_q;
          res.ctrl   = normal_ctrl(op_q, wrap_cycle_q);
          res.full   = 1'b1;
          res.bell   = 1'b1;
          res.last   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Hold or drop the output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= utrp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the request and the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= op_in;
      op_known_q  <= op_known_in;
      range_err_q <= range_err;
      slot_q      <= slot_i;
      dci_q       <= ep_idx;
      buf_addr_q  <= address_i;
      len_q       <= length_i;
      tbl_addr_q  <= rd_addr;
    end
    wrap_cycle_q <= wrap_cycle_d;
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_slot_o       = out_q.slot;
  assign out_dci_o        = out_q.dci;
  assign entry_index_o    = out_q.entry;
  assign parameter_word_o = out_q.param;
  assign status_word_o    = out_q.status;
  assign control_word_o   = out_q.ctrl;
  assign write_full_o     = out_q.full;
  assign ring_doorbell_o  = out_q.bell;
  assign result_code_o    = out_q.code;
  assign last_o           = out_q.last;

endmodule

### rtl/core/utrp_checker.sv
// Port-level checks of the transfer ring producer and their binding.
`include "usb_transfer_ring_producer_defines.svh"

module utrp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       write_full_o,
  input logic       ring_doorbell_o,
  input logic [1:0] result_code_o,
  input logic       last_o
);

  // Hold a stalled result
  `UTRP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

  // A doorbell only comes with a full, final TRB write
  `UTRP_ASSERT_IMP(a_bell_full, out_valid_o && ring_doorbell_o, write_full_o && last_o)

  // An error result is final and writes nothing
  `UTRP_ASSERT_IMP(a_err_final, out_valid_o && (result_code_o != utrp_pkg::RES_OK),
                   last_o && !write_full_o && !ring_doorbell_o)

  // A link rewrite blocks new requests until its normal TRB follows
  `UTRP_ASSERT_IMP(a_link_block, out_valid_o && !last_o, !in_ready_o)

  // The normal TRB follows the link rewrite at once
  `UTRP_ASSERT_NEXT(a_link_next, out_valid_o && out_ready_i && !last_o,
                    out_valid_o && last_o && write_full_o)

endmodule

bind usb_transfer_ring_producer utrp_checker u_checker (.*);
